### sv/frpm_pkg.sv
// ----------------------------------------------------------------------------
// frpm_pkg
// Shared constants for the frame pacer rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package frpm_pkg;

  localparam int MAX_RATE_DEF = 256;

  localparam int TIME_W   = 63;
  localparam int RATE_REG_W = 9;
  localparam int COUNT_W  = 9;
  localparam int PERIOD_W = 30;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [PERIOD_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [RATE_REG_W-1:0] TARGET_RATE_RST = 9'd60;

  // register index of target_rate (paddr[2])
  localparam logic REG_TARGET_RATE = 1'b0;

endpackage

`default_nettype wire

### sv/frpm_div.sv
// ----------------------------------------------------------------------------
// frpm_div
// Iterative restoring divider: one billion over the effective rate, one
// quotient bit per cycle. Holds the frame period between runs.
// ----------------------------------------------------------------------------
`default_nettype none

module frpm_div #(
  parameter int RATE_W = 9,
  parameter logic [frpm_pkg::PERIOD_W-1:0] PERIOD_RST = 30'd16666666
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [RATE_W-1:0]             divisor,
  output logic                               busy,
  output logic [frpm_pkg::PERIOD_W-1:0]      period
);

  localparam int PW = frpm_pkg::PERIOD_W;
  localparam logic [4:0] LAST_BIT = 5'(PW - 1);

  logic              busy_r;
  logic [4:0]        bit_r;
  logic [RATE_W-1:0] dvs_r;
  logic [RATE_W-1:0] rem_r;
  logic [PW-1:0]     quo_r;

  logic [RATE_W:0]   trial;
  logic              take;

  assign trial = {rem_r, frpm_pkg::NS_PER_SEC[bit_r]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= LAST_BIT;
      quo_r  <= PERIOD_RST;
    end else if (start) begin
      busy_r <= 1'b1;
      bit_r  <= LAST_BIT;
    end else if (busy_r) begin
      quo_r <= {quo_r[PW-2:0], take};
      if (bit_r == 5'd0) begin
        busy_r <= 1'b0;
      end else begin
        bit_r <= bit_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? RATE_W'(trial - {1'b0, dvs_r}) : RATE_W'(trial);
    end
  end

  assign busy   = busy_r;
  assign period = quo_r;

endmodule

`default_nettype wire

### sv/frpm_ring.sv
// ----------------------------------------------------------------------------
// frpm_ring
// Delta history memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module frpm_ring #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 63
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/frame_pacer_rate_meter.sv
// ----------------------------------------------------------------------------
// frame_pacer_rate_meter
// Non-firing word: S_CHECK, then back to S_IDLE and ready. Firing word: S_CHECK,
// then the one-entry-per-cycle backward walk over the delta ring, then S_OUT.
// After a target_rate write, in_ready stays low while the period divide runs.
// Reset: synchronous; a clearing pass over all MAX_RATE slots zeroes the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pacer_rate_meter #(
  parameter int MAX_RATE = frpm_pkg::MAX_RATE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [frpm_pkg::TIME_W-1:0]     in_time_now_ns,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [frpm_pkg::COUNT_W-1:0]         out_frames_in_second,
  output logic [frpm_pkg::TIME_W-1:0]          out_frame_delta_ns,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [frpm_pkg::APB_AW-1:0]     paddr,
  input  wire logic [frpm_pkg::APB_DW-1:0]     pwdata,
  output logic [frpm_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  localparam int TW       = frpm_pkg::TIME_W;
  localparam int PW       = frpm_pkg::PERIOD_W;
  localparam int RW       = frpm_pkg::RATE_REG_W;
  localparam int RATE_W   = $clog2(MAX_RATE + 1);
  localparam int SLOT_W   = (MAX_RATE > 1) ? $clog2(MAX_RATE) : 1;
  localparam int CMP_W    = (RATE_W > RW) ? RATE_W : RW;
  localparam int RST_RATE = (MAX_RATE < 60) ? MAX_RATE : 60;
  localparam logic [PW-1:0] PERIOD_RST = PW'(1000000000 / RST_RATE);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_RATE - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [RW-1:0]     target_rate_r;
  logic              div_start_r;
  logic              base_vld_r;
  logic [TW-1:0]     base_r;
  logic [TW-1:0]     now_r;
  logic [TW-1:0]     delta_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] clr_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic              rd_vld_r;
  logic [PW-1:0]     total_r;
  logic [RATE_W-1:0] tally_r;

  logic              div_busy;
  logic [PW-1:0]     period;
  logic [RATE_W-1:0] eff_rate;
  logic [CMP_W-1:0]  tr_ext;
  logic              cfg_wr;
  logic              in_acc;
  logic [TW:0]       diff;
  logic              fire;
  logic [SLOT_W-1:0] slot_eff;
  logic [RATE_W-1:0] slot_inc;
  logic              ring_we;
  logic [SLOT_W-1:0] ring_waddr;
  logic [TW-1:0]     ring_wdata;
  logic [TW-1:0]     ring_q;
  logic [TW:0]       sum;
  logic              over;
  logic [RATE_W-1:0] tally_inc;
  logic              walk_end;

  // effective rate clamp
  always_comb begin
    tr_ext = CMP_W'(target_rate_r);
    priority if (tr_ext == '0) begin
      eff_rate = RATE_W'(1);
    end else if (tr_ext > CMP_W'(MAX_RATE)) begin
      eff_rate = RATE_W'(MAX_RATE);
    end else begin
      eff_rate = RATE_W'(tr_ext);
    end
  end

  assign pready = 1'b1;
  assign prdata = frpm_pkg::APB_DW'(target_rate_r);
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == frpm_pkg::REG_TARGET_RATE);

  assign in_ready = (state_r == S_IDLE) && !div_busy && !div_start_r;
  assign in_acc   = in_valid && in_ready;

  assign diff = {1'b0, now_r} - {1'b0, base_r};
  assign fire = base_vld_r && !diff[TW] && (diff[TW-1:0] >= TW'(period));

  assign slot_eff = (RATE_W'(slot_r) >= eff_rate) ? '0 : slot_r;
  assign slot_inc = RATE_W'(slot_eff) + RATE_W'(1);

  assign ring_we    = (state_r == S_CLEAR) || ((state_r == S_CHECK) && fire);
  assign ring_waddr = (state_r == S_CLEAR) ? clr_r : slot_eff;
  assign ring_wdata = (state_r == S_CLEAR) ? '0 : diff[TW-1:0];

  // total stays at or below one billion, so this add never overflows
  assign sum       = {1'b0, (TW - PW)'(0), total_r} + {1'b0, ring_q};
  assign over      = sum > (TW + 1)'(frpm_pkg::NS_PER_SEC);
  assign tally_inc = tally_r + RATE_W'(1);
  assign walk_end  = rd_vld_r && (over || (tally_inc == eff_rate));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == SLOT_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_CHECK;
      S_CHECK: state_nxt = fire ? S_WALK : S_IDLE;
      S_WALK:  if (walk_end) state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      target_rate_r <= frpm_pkg::TARGET_RATE_RST;
      div_start_r   <= 1'b0;
      base_vld_r    <= 1'b0;
      base_r        <= '0;
      slot_r        <= '0;
      clr_r         <= '0;
      rd_vld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= cfg_wr;
      if (cfg_wr) begin
        target_rate_r <= pwdata[RW-1:0];
      end
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + SLOT_W'(1);
      end
      if (state_r == S_CHECK) begin
        if (!base_vld_r) begin
          base_vld_r <= 1'b1;
          base_r     <= now_r;
        end else if (fire) begin
          base_r <= now_r;
          slot_r <= (slot_inc >= eff_rate) ? '0 : SLOT_W'(slot_inc);
        end
        rd_vld_r <= 1'b0;
      end else if (state_r == S_WALK) begin
        rd_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_time_now_ns;
    end
    if (state_r == S_CHECK) begin
      delta_r  <= diff[TW-1:0];
      rd_idx_r <= slot_eff;
      total_r  <= '0;
      tally_r  <= '0;
    end else if (state_r == S_WALK) begin
      rd_idx_r <= (rd_idx_r == '0) ? SLOT_W'(eff_rate - RATE_W'(1))
                                    : rd_idx_r - SLOT_W'(1);
      if (rd_vld_r && !over && !walk_end) begin
        total_r <= sum[PW-1:0];
        tally_r <= tally_inc;
      end else if (rd_vld_r && !over) begin
        tally_r <= tally_inc;
      end
    end
  end

  frpm_div #(
    .RATE_W     (RATE_W),
    .PERIOD_RST (PERIOD_RST)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start_r),
    .divisor (eff_rate),
    .busy    (div_busy),
    .period  (period)
  );

  frpm_ring #(
    .DEPTH (MAX_RATE),
    .AW    (SLOT_W),
    .DW    (TW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (state_r == S_WALK),
    .raddr (rd_idx_r),
    .rdata (ring_q)
  );

  assign out_valid            = (state_r == S_OUT);
  assign out_frames_in_second = frpm_pkg::COUNT_W'(tally_r);
  assign out_frame_delta_ns   = delta_r;

endmodule

`default_nettype wire
